// ===== sv/congestion_window_control_macros.svh =====
// ---------------------------------------------------------------------------
// congestion window control assertion macros
// shared property wrappers for the controller, datapath and divider
// ---------------------------------------------------------------------------
`ifndef CONGESTION_WINDOW_CONTROL_MACROS_SVH
`define CONGESTION_WINDOW_CONTROL_MACROS_SVH

// same-cycle implication
`define CWC_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CWC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cwc_pkg.sv =====
// ---------------------------------------------------------------------------
// cwc_pkg
// widths, codes and control types of the congestion window controller
// ---------------------------------------------------------------------------
package cwc_pkg;

   localparam int Q_W        = 32;
   localparam int SEQ_W      = 31;
   localparam int CMD_W      = 2;
   localparam int PHASE_W    = 2;
   localparam int DUP_W      = 2;
   localparam int WIN_CFG_W  = 11;
   localparam int THR_CFG_W  = 16;
   localparam int LIMIT_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [WIN_CFG_W-1:0] WIN_CFG_RESET   = 11'd10;
   localparam logic [THR_CFG_W-1:0] THR_CFG_RESET   = 16'd200;
   localparam logic [LIMIT_W-1:0]   LIMIT_CFG_RESET = 2'd3;
   localparam logic [DUP_W-1:0]     DUP_MAX         = 2'd3;

   localparam logic [CMD_W-1:0] CMD_ACK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FINAL   = 2'd2;

   localparam logic [PHASE_W-1:0] PHASE_SLOW     = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_AVOID    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_RECOVERY = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_WAIT     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CFG_INIT_WINDOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_INIT_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_DUP_ACK_LIMIT  = 2'd2;

   typedef struct packed {
      logic load_input;
      logic div_start;
      logic commit;
   } cwc_ctrl_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
   } cwc_status_type;

endpackage

// ===== sv/congestion_window_control.sv =====
// new-ack in avoidance (or leaving slow start): accept, decide, run the divider, commit
// every other word: accept, decide, commit
// one word at a time: next accept in the cycle after commit; commit waits for a free result register
// the avoidance rate is set by the bit-serial reciprocal divider, one quotient bit a cycle
// reset (synchronous, active high): waiting for first ack, window 10, threshold 200 packets,
// config 10 / 200 / 3; no clearing pass, words accepted right after reset
// ---------------------------------------------------------------------------
// congestion_window_control
// reno-style sender congestion window controller, one result per event word
// ---------------------------------------------------------------------------
module congestion_window_control #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cwc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [cwc_pkg::SEQ_W-1:0]       req_ack_number,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cwc_pkg::Q_W-1:0]         rsp_window,
   output logic [cwc_pkg::Q_W-1:0]         rsp_threshold,
   output logic [cwc_pkg::SEQ_W-1:0]       rsp_base_sequence,
   output logic                            rsp_resend,
   output logic [cwc_pkg::SEQ_W-1:0]       rsp_resend_sequence,
   output logic [cwc_pkg::PHASE_W-1:0]     rsp_phase,
   output logic                            rsp_finished,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cwc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cwc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cwc_pkg::*;

   cwc_ctrl_type   ctrl;
   cwc_status_type status;

   cwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .status    (status)
   );

   cwc_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .status              (status),
      .req_cmd             (req_cmd),
      .req_ack_number      (req_ack_number),
      .rsp_window          (rsp_window),
      .rsp_threshold       (rsp_threshold),
      .rsp_base_sequence   (rsp_base_sequence),
      .rsp_resend          (rsp_resend),
      .rsp_resend_sequence (rsp_resend_sequence),
      .rsp_phase           (rsp_phase),
      .rsp_finished        (rsp_finished),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

// ===== sv/cwc_recip.sv =====
// ---------------------------------------------------------------------------
// cwc_recip
// bit-serial restoring divider giving floor(2^(2*FRAC_BITS) / divisor)
// ---------------------------------------------------------------------------
`include "congestion_window_control_macros.svh"

module cwc_recip #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cwc_pkg::Q_W-1:0]     divisor,
   output logic                        busy,
   output logic [2*FRAC_BITS:0]        quotient
);
   import cwc_pkg::*;

   localparam int QT_W  = 2 * FRAC_BITS + 1;
   localparam int CNT_W = $clog2(QT_W + 1);

   logic             busy_ff,  busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [Q_W-1:0]   rem_ff,   rem_in;
   logic [QT_W-1:0]  quot_ff,  quot_in;
   logic [Q_W-1:0]   div_ff,   div_in;
   logic [Q_W:0]     trial;
   logic [Q_W:0]     diff;
   logic             fits;

   always_comb begin
      trial    = {rem_ff, quot_ff[QT_W-1]};
      diff     = trial - {1'b0, div_ff};
      fits     = trial >= {1'b0, div_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(QT_W);
         rem_in   = '0;
         // dividend is a single one at the top bit, shifted out first
         quot_in  = QT_W'(1) << (2 * FRAC_BITS);
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[Q_W-1:0] : trial[Q_W-1:0];
         quot_in  = {quot_ff[QT_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

   `CWC_ASSERT_NOW(a_busy_has_count, clock, reset, busy_ff, count_ff != '0, "divider busy with no steps left")

endmodule

// ===== sv/cwc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cwc_ctrl
// sequencer: take a word, decide, run the divider if needed, commit result
// ---------------------------------------------------------------------------
`include "congestion_window_control_macros.svh"

module cwc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cwc_pkg::cwc_ctrl_type   ctrl,
   input  cwc_pkg::cwc_status_type status
);
   import cwc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load_input = 1'b1;
               state_in        = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.need_div) begin
               ctrl.div_start = 1'b1;
               state_in       = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // the output register must be free before the state moves on
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.commit  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `CWC_ASSERT_NEXT(a_accept_to_calc, clock, reset, req_valid && req_ready, state_ff == ST_CALC, "accepted word did not reach decision")
   `CWC_ASSERT_NEXT(a_commit_shows, clock, reset, ctrl.commit, rsp_valid_ff, "committed result not presented")
   `CWC_ASSERT_NOW(a_start_in_calc, clock, reset, ctrl.div_start, state_ff == ST_CALC && !status.div_busy, "divider started out of sequence")

endmodule

// ===== sv/cwc_datapath.sv =====
// ---------------------------------------------------------------------------
// cwc_datapath
// config registers, connection state, next-state logic and result register
// ---------------------------------------------------------------------------
`include "congestion_window_control_macros.svh"

module cwc_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cwc_pkg::cwc_ctrl_type           ctrl,
   output cwc_pkg::cwc_status_type         status,
   input  logic [cwc_pkg::CMD_W-1:0]       req_cmd,
   input  logic [cwc_pkg::SEQ_W-1:0]       req_ack_number,
   output logic [cwc_pkg::Q_W-1:0]         rsp_window,
   output logic [cwc_pkg::Q_W-1:0]         rsp_threshold,
   output logic [cwc_pkg::SEQ_W-1:0]       rsp_base_sequence,
   output logic                            rsp_resend,
   output logic [cwc_pkg::SEQ_W-1:0]       rsp_resend_sequence,
   output logic [cwc_pkg::PHASE_W-1:0]     rsp_phase,
   output logic                            rsp_finished,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cwc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cwc_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cwc_pkg::*;

   localparam int QT_W   = 2 * FRAC_BITS + 1;
   localparam int WIDE_W = Q_W + THR_CFG_W;
   localparam int EXT_W  = 2 * Q_W;
   localparam logic [Q_W-1:0] ONE_Q   = Q_W'(1) << FRAC_BITS;
   localparam logic [Q_W-1:0] THREE_Q = ONE_Q + (ONE_Q << 1);

   function automatic logic [Q_W-1:0] to_q(input logic [THR_CFG_W-1:0] pkts);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(pkts) << FRAC_BITS;
      return (|wide[WIDE_W-1:Q_W]) ? '1 : wide[Q_W-1:0];
   endfunction

   function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] a,
                                              input logic [Q_W-1:0] b);
      logic [Q_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[Q_W] ? '1 : s[Q_W-1:0];
   endfunction

   // configuration
   logic [WIN_CFG_W-1:0] cfg_win_ff;
   logic [THR_CFG_W-1:0] cfg_thr_ff;
   logic [LIMIT_W-1:0]   cfg_limit_ff;

   // latched word
   logic [CMD_W-1:0] cmd_ff;
   logic [SEQ_W-1:0] ack_ff;

   // connection state
   logic [PHASE_W-1:0] phase_ff,     phase_in;
   logic [Q_W-1:0]     window_ff,    window_in;
   logic [Q_W-1:0]     threshold_ff, threshold_in;
   logic [SEQ_W-1:0]   base_ff,      base_in;
   logic [DUP_W-1:0]   dup_ff,       dup_in;
   logic               done_ff,      done_in;
   logic               resend_in;
   logic [SEQ_W-1:0]   resend_seq_in;

   // result register
   logic [Q_W-1:0]     rsp_window_ff;
   logic [Q_W-1:0]     rsp_threshold_ff;
   logic [SEQ_W-1:0]   rsp_base_ff;
   logic               rsp_resend_ff;
   logic [SEQ_W-1:0]   rsp_resend_seq_ff;
   logic [PHASE_W-1:0] rsp_phase_ff;
   logic               rsp_finished_ff;

   logic               div_busy;
   logic [QT_W-1:0]    quotient;
   logic [EXT_W-1:0]   quot_ext;
   logic [Q_W-1:0]     avoid_window;
   logic [Q_W-1:0]     init_win_q;
   logic [Q_W-1:0]     init_thr_q;
   logic [Q_W-1:0]     half_window;
   logic [SEQ_W-1:0]   ack_next;
   logic               is_new;
   logic               leave_slow;
   logic [PHASE_W-1:0] work_phase;
   logic [DUP_W-1:0]   dup_sat;

   cwc_recip #(
      .FRAC_BITS (FRAC_BITS)
   ) u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .divisor  (window_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      init_win_q  = to_q(THR_CFG_W'(cfg_win_ff));
      init_thr_q  = to_q(cfg_thr_ff);
      half_window = window_ff >> 1;
      ack_next    = ack_ff + SEQ_W'(1);
      is_new      = base_ff <= ack_ff;
      leave_slow  = (phase_ff == PHASE_SLOW) && (window_ff >= threshold_ff);
      work_phase  = leave_slow ? PHASE_AVOID : phase_ff;
      dup_sat     = (dup_ff < DUP_MAX) ? dup_ff + DUP_W'(1) : dup_ff;
      quot_ext    = EXT_W'(quotient);
      // zero window or an increment past the word width saturates
      if (window_ff == '0 || (|quot_ext[EXT_W-1:Q_W])) begin
         avoid_window = '1;
      end else begin
         avoid_window = sat_add(window_ff, quot_ext[Q_W-1:0]);
      end
   end

   always_comb begin
      status.need_div = !done_ff && (cmd_ff == CMD_ACK) && is_new &&
                        (work_phase == PHASE_AVOID);
      status.div_busy = div_busy;
   end

   always_comb begin
      phase_in      = phase_ff;
      window_in     = window_ff;
      threshold_in  = threshold_ff;
      base_in       = base_ff;
      dup_in        = dup_ff;
      done_in       = done_ff;
      resend_in     = 1'b0;
      resend_seq_in = '0;
      if (!done_ff) begin
         unique case (cmd_ff)
            CMD_FINAL: begin
               done_in = 1'b1;
            end
            CMD_TIMEOUT: begin
               threshold_in  = half_window;
               window_in     = init_win_q;
               phase_in      = PHASE_SLOW;
               dup_in        = '0;
               resend_in     = 1'b1;
               resend_seq_in = base_ff;
            end
            CMD_ACK: begin
               if (phase_ff == PHASE_WAIT) begin
                  // first ack loads the window and counts as neither kind
                  window_in    = init_win_q;
                  threshold_in = init_thr_q;
                  dup_in       = '0;
                  base_in      = ack_next;
                  phase_in     = (init_win_q >= init_thr_q) ? PHASE_AVOID : PHASE_SLOW;
               end else if (phase_ff == PHASE_RECOVERY) begin
                  if (is_new) begin
                     window_in = threshold_ff;
                     dup_in    = '0;
                     base_in   = ack_next;
                     phase_in  = PHASE_AVOID;
                  end else begin
                     window_in = sat_add(window_ff, ONE_Q);
                  end
               end else begin
                  phase_in = work_phase;
                  if (is_new) begin
                     window_in = (work_phase == PHASE_SLOW) ?
                                 sat_add(window_ff, ONE_Q) : avoid_window;
                     dup_in    = '0;
                     base_in   = ack_next;
                  end else if (dup_sat >= cfg_limit_ff) begin
                     // fast retransmit
                     threshold_in  = half_window;
                     window_in     = sat_add(half_window, THREE_Q);
                     phase_in      = PHASE_RECOVERY;
                     dup_in        = '0;
                     resend_in     = 1'b1;
                     resend_seq_in = ack_next;
                  end else begin
                     dup_in = dup_sat;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_win_ff   <= WIN_CFG_RESET;
         cfg_thr_ff   <= THR_CFG_RESET;
         cfg_limit_ff <= LIMIT_CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CFG_INIT_WINDOW:    cfg_win_ff   <= csr_data[WIN_CFG_W-1:0];
            CFG_INIT_THRESHOLD: cfg_thr_ff   <= csr_data[THR_CFG_W-1:0];
            CFG_DUP_ACK_LIMIT:  cfg_limit_ff <= csr_data[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_WAIT;
         window_ff    <= to_q(THR_CFG_W'(WIN_CFG_RESET));
         threshold_ff <= to_q(THR_CFG_RESET);
         base_ff      <= '0;
         dup_ff       <= '0;
         done_ff      <= 1'b0;
      end else if (ctrl.commit) begin
         phase_ff     <= phase_in;
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
         base_ff      <= base_in;
         dup_ff       <= dup_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_input) begin
         cmd_ff <= req_cmd;
         ack_ff <= req_ack_number;
      end
      if (ctrl.commit) begin
         rsp_window_ff     <= window_in;
         rsp_threshold_ff  <= threshold_in;
         rsp_base_ff       <= base_in;
         rsp_resend_ff     <= resend_in;
         rsp_resend_seq_ff <= resend_seq_in;
         rsp_phase_ff      <= phase_in;
         rsp_finished_ff   <= done_in;
      end
   end

   assign csr_ready           = 1'b1;
   assign rsp_window          = rsp_window_ff;
   assign rsp_threshold       = rsp_threshold_ff;
   assign rsp_base_sequence   = rsp_base_ff;
   assign rsp_resend          = rsp_resend_ff;
   assign rsp_resend_sequence = rsp_resend_seq_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_finished        = rsp_finished_ff;

   `CWC_ASSERT_NEXT(a_result_tracks_state, clock, reset, ctrl.commit, rsp_window_ff == window_ff && rsp_phase_ff == phase_ff, "result word differs from committed state")

endmodule
